### design/mrs256_pkg.sv
package mrs256_pkg;

    localparam int MAX_DEPTH_DEF = 32;
    localparam int NODE_W = 256;

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef logic [31:0] word32_t;

    function automatic word32_t rotr(input word32_t x, input int n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic word32_t swap32(input word32_t x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

### design/merkle_root_sha256_top.sv
// A word that does not close a chunk is only buffered; a word that closes a chunk hashes
// each carried SHA-256 pair (one round per cycle, shared unit).
// The final word walks the closing levels and hashes each closing pair, then the length
// mix, then four output transfers follow; s_tready stays low until the last one is taken.
// After reset the zero-subtree table is built, with s_tready low.
// aresetn is synchronous, active low; it clears control state and the config.
module merkle_root_sha256_top #(
    parameter int MAX_DEPTH = mrs256_pkg::MAX_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // data_word[63:0], valid_bytes[67:64], zero fill
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // root_word[63:0]
    output logic [2:0]   m_tuser,   // word_index[1:0], overflow_error[2]
    output logic         m_tlast
);

    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int CW = MAX_DEPTH + 2;
    localparam int NW = mrs256_pkg::NODE_W;

    localparam logic [3:0] S_ZINIT = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PLOOK = 4'd2;
    localparam logic [3:0] S_LOAD  = 4'd3;
    localparam logic [3:0] S_ROUND = 4'd4;
    localparam logic [3:0] S_ADD   = 4'd5;
    localparam logic [3:0] S_RET   = 4'd6;
    localparam logic [3:0] S_FSET  = 4'd7;
    localparam logic [3:0] S_FLOOK = 4'd8;
    localparam logic [3:0] S_FROOT = 4'd9;
    localparam logic [3:0] S_MIX   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    localparam logic [1:0] RET_ZERO = 2'd0;
    localparam logic [1:0] RET_PUSH = 2'd1;
    localparam logic [1:0] RET_FIN  = 2'd2;
    localparam logic [1:0] RET_MIX  = 2'd3;

    localparam logic [1:0] REG_DEPTH = 2'd0;
    localparam logic [1:0] REG_MIXEN = 2'd1;
    localparam logic [1:0] REG_MIXLEN = 2'd2;

    localparam logic [CW-1:0] CAP = CW'(1) << MAX_DEPTH;
    localparam logic [LW-1:0] MAXL = LW'(MAX_DEPTH);

    logic [3:0]  state_reg;
    logic [1:0]  ret_reg;
    logic [5:0]  depth_reg;
    logic        mixen_reg;
    logic [63:0] mixlen_reg;
    logic [63:0] cbuf_reg [4];
    logic [1:0]  wpos_reg;
    logic [CW-1:0] total_reg;
    logic [MAX_DEPTH:0] pvalid_reg;
    logic        last_reg;
    logic        have_reg;
    logic        err_reg;
    logic [LW-1:0] lev_reg;
    logic [LW-1:0] d_reg;
    logic [1:0]  oidx_reg;
    logic [NW-1:0] node_reg;
    logic [NW-1:0] pq_reg;
    logic [NW-1:0] zq_reg;
    logic [NW-1:0] pend_mem [MAX_DEPTH+1];
    logic [NW-1:0] zero_mem [MAX_DEPTH+1];
    logic        pw_en;
    logic        zw_en;

    logic [31:0] sched_reg [16];
    logic [31:0] wk_reg [8];
    logic [31:0] hs_reg [8];
    logic [5:0]  rnd_reg;
    logic        blk_reg;

    logic        s_acc;
    logic [63:0] mword;
    logic [3:0]  vbe;
    logic [NW-1:0] chunk_next;
    logic [NW-1:0] opl;
    logic [NW-1:0] opr;
    logic [511:0] msg;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] wnew;
    logic [31:0] hsum [8];
    logic [NW-1:0] hout;
    logic [CW-1:0] cnt;
    logic [CW-1:0] cntm1;
    logic [LW-1:0] fit;
    logic [LW-1:0] cfgd;
    logic [LW-1:0] lim;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = node_reg[64*oidx_reg +: 64];
    assign m_tuser  = {err_reg, oidx_reg};
    assign m_tlast  = (oidx_reg == 2'd3);

    always_comb begin
        vbe = s_tdata[67:64];
        if (!s_tlast || vbe == 4'd0 || vbe > 4'd8) begin
            vbe = 4'd8;
        end
        for (int j = 0; j < 8; j++) begin
            mword[8*j +: 8] = (4'(j) < vbe) ? s_tdata[8*j +: 8] : 8'd0;
        end
        for (int k = 0; k < 4; k++) begin
            chunk_next[64*k +: 64] = (2'(k) == wpos_reg) ? mword : cbuf_reg[k];
        end
    end

    always_comb begin
        opl = node_reg;
        opr = node_reg;
        case (ret_reg)
            RET_PUSH: begin
                opl = pq_reg;
            end
            RET_FIN: begin
                if (pvalid_reg[lev_reg]) begin
                    opl = pq_reg;
                    opr = have_reg ? node_reg : zq_reg;
                end else begin
                    opr = zq_reg;
                end
            end
            RET_MIX: begin
                opr = {192'd0, mixlen_reg};
            end
            default: begin
            end
        endcase
        msg = {opr, opl};
    end

    always_comb begin
        logic [31:0] e, a, s1e, ch, s0a, maj, sg0, sg1;
        e   = wk_reg[4];
        a   = wk_reg[0];
        s1e = mrs256_pkg::rotr(e, 6) ^ mrs256_pkg::rotr(e, 11) ^ mrs256_pkg::rotr(e, 25);
        ch  = (e & wk_reg[5]) ^ (~e & wk_reg[6]);
        s0a = mrs256_pkg::rotr(a, 2) ^ mrs256_pkg::rotr(a, 13) ^ mrs256_pkg::rotr(a, 22);
        maj = (a & wk_reg[1]) ^ (a & wk_reg[2]) ^ (wk_reg[1] & wk_reg[2]);
        t1  = wk_reg[7] + s1e + ch + mrs256_pkg::RK[rnd_reg] + sched_reg[0];
        t2  = s0a + maj;
        sg0 = mrs256_pkg::rotr(sched_reg[1], 7) ^ mrs256_pkg::rotr(sched_reg[1], 18)
            ^ (sched_reg[1] >> 3);
        sg1 = mrs256_pkg::rotr(sched_reg[14], 17) ^ mrs256_pkg::rotr(sched_reg[14], 19)
            ^ (sched_reg[14] >> 10);
        wnew = sched_reg[0] + sg0 + sched_reg[9] + sg1;
        for (int i = 0; i < 8; i++) begin
            hsum[i] = hs_reg[i] + wk_reg[i];
        end
        for (int k = 0; k < 4; k++) begin
            hout[64*k +: 32]      = mrs256_pkg::swap32(hsum[2*k]);
            hout[64*k + 32 +: 32] = mrs256_pkg::swap32(hsum[2*k+1]);
        end
    end

    always_comb begin
        cnt   = (total_reg < CAP) ? total_reg : CAP;
        cntm1 = cnt - CW'(1);
        fit   = '0;
        if (cnt > CW'(1)) begin
            for (int i = 0; i < CW; i++) begin
                if (cntm1[i]) begin
                    fit = LW'(i + 1);
                end
            end
        end
        cfgd = (depth_reg > 6'(MAX_DEPTH)) ? MAXL : LW'(depth_reg);
        lim  = (cfgd != '0) ? cfgd : MAXL;
    end

    assign pw_en = (state_reg == S_PLOOK) && !((lev_reg < MAXL) && pvalid_reg[lev_reg]);
    assign zw_en = (state_reg == S_ZINIT) || (state_reg == S_RET && ret_reg == RET_ZERO);

    always_ff @(posedge aclk) begin
        if (pw_en) begin
            pend_mem[lev_reg] <= node_reg;
        end
        pq_reg <= pend_mem[lev_reg];
    end

    always_ff @(posedge aclk) begin
        if (zw_en) begin
            zero_mem[lev_reg] <= (state_reg == S_ZINIT) ? '0 : node_reg;
        end
        zq_reg <= zero_mem[lev_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg  <= '0;
            mixen_reg  <= 1'b0;
            mixlen_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DEPTH:  depth_reg  <= cfg_wdata[5:0];
                REG_MIXEN:  mixen_reg  <= cfg_wdata[0];
                REG_MIXLEN: mixlen_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_ZINIT;
            ret_reg    <= RET_ZERO;
            wpos_reg   <= '0;
            total_reg  <= '0;
            pvalid_reg <= '0;
            last_reg   <= 1'b0;
            have_reg   <= 1'b0;
            err_reg    <= 1'b0;
            lev_reg    <= '0;
            d_reg      <= '0;
            oidx_reg   <= '0;
            rnd_reg    <= '0;
            blk_reg    <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                cbuf_reg[k] <= '0;
            end
        end else begin
            unique case (state_reg)
                S_ZINIT: begin
                    node_reg <= '0;
                    lev_reg  <= LW'(1);
                    ret_reg  <= RET_ZERO;
                    state_reg <= S_LOAD;
                end
                S_IDLE: begin
                    if (s_acc) begin
                        last_reg <= s_tlast;
                        if (wpos_reg == 2'd3 || s_tlast) begin
                            node_reg <= chunk_next;
                            wpos_reg <= '0;
                            for (int k = 0; k < 4; k++) begin
                                cbuf_reg[k] <= '0;
                            end
                            lev_reg <= '0;
                            if (total_reg < CAP) begin
                                state_reg <= S_PLOOK;
                            end else begin
                                if (total_reg == CAP) begin
                                    total_reg <= total_reg + CW'(1);
                                end
                                state_reg <= s_tlast ? S_FSET : S_IDLE;
                            end
                        end else begin
                            cbuf_reg[wpos_reg] <= mword;
                            wpos_reg <= wpos_reg + 2'd1;
                        end
                    end
                end
                S_PLOOK: begin
                    if ((lev_reg < MAXL) && pvalid_reg[lev_reg]) begin
                        ret_reg   <= RET_PUSH;
                        state_reg <= S_LOAD;
                    end else begin
                        pvalid_reg[lev_reg] <= 1'b1;
                        total_reg <= total_reg + CW'(1);
                        state_reg <= last_reg ? S_FSET : S_IDLE;
                    end
                end
                S_LOAD: begin
                    for (int k = 0; k < 8; k++) begin
                        sched_reg[2*k]   <= mrs256_pkg::swap32(msg[64*k +: 32]);
                        sched_reg[2*k+1] <= mrs256_pkg::swap32(msg[64*k + 32 +: 32]);
                    end
                    for (int i = 0; i < 8; i++) begin
                        wk_reg[i] <= mrs256_pkg::IV[i];
                        hs_reg[i] <= mrs256_pkg::IV[i];
                    end
                    rnd_reg   <= '0;
                    blk_reg   <= 1'b0;
                    state_reg <= S_ROUND;
                end
                S_ROUND: begin
                    wk_reg[7] <= wk_reg[6];
                    wk_reg[6] <= wk_reg[5];
                    wk_reg[5] <= wk_reg[4];
                    wk_reg[4] <= wk_reg[3] + t1;
                    wk_reg[3] <= wk_reg[2];
                    wk_reg[2] <= wk_reg[1];
                    wk_reg[1] <= wk_reg[0];
                    wk_reg[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++) begin
                        sched_reg[i] <= sched_reg[i+1];
                    end
                    sched_reg[15] <= wnew;
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63) begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (!blk_reg) begin
                        for (int i = 0; i < 8; i++) begin
                            hs_reg[i] <= hsum[i];
                            wk_reg[i] <= hsum[i];
                        end
                        for (int i = 1; i < 15; i++) begin
                            sched_reg[i] <= '0;
                        end
                        sched_reg[0]  <= 32'h80000000;
                        sched_reg[15] <= 32'd512;
                        blk_reg   <= 1'b1;
                        rnd_reg   <= '0;
                        state_reg <= S_ROUND;
                    end else begin
                        node_reg  <= hout;
                        state_reg <= S_RET;
                    end
                end
                S_RET: begin
                    unique case (ret_reg)
                        RET_ZERO: begin
                            if (lev_reg == MAXL) begin
                                state_reg <= S_IDLE;
                            end else begin
                                lev_reg   <= lev_reg + LW'(1);
                                state_reg <= S_LOAD;
                            end
                        end
                        RET_PUSH: begin
                            pvalid_reg[lev_reg] <= 1'b0;
                            lev_reg   <= lev_reg + LW'(1);
                            state_reg <= S_PLOOK;
                        end
                        RET_FIN: begin
                            have_reg  <= 1'b1;
                            lev_reg   <= lev_reg + LW'(1);
                            state_reg <= S_FLOOK;
                        end
                        default: begin
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_FSET: begin
                    err_reg   <= total_reg > (CW'(1) << lim);
                    d_reg     <= (cfgd > fit) ? cfgd : fit;
                    lev_reg   <= '0;
                    have_reg  <= 1'b0;
                    state_reg <= S_FLOOK;
                end
                S_FLOOK: begin
                    if (lev_reg == d_reg) begin
                        state_reg <= have_reg ? S_MIX : S_FROOT;
                    end else if (pvalid_reg[lev_reg] || have_reg) begin
                        ret_reg   <= RET_FIN;
                        state_reg <= S_LOAD;
                    end else begin
                        lev_reg <= lev_reg + LW'(1);
                    end
                end
                S_FROOT: begin
                    node_reg  <= pq_reg;
                    state_reg <= S_MIX;
                end
                S_MIX: begin
                    oidx_reg <= '0;
                    if (mixen_reg) begin
                        ret_reg   <= RET_MIX;
                        state_reg <= S_LOAD;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        oidx_reg <= oidx_reg + 2'd1;
                        if (oidx_reg == 2'd3) begin
                            total_reg  <= '0;
                            pvalid_reg <= '0;
                            wpos_reg   <= '0;
                            state_reg  <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH_CAP = mrs256_pkg::MAX_DEPTH_DEF;
    localparam logic [1:0] REG_TREE_DEPTH = 2'd0;
    localparam logic [1:0] REG_MIX_ENABLE = 2'd1;
    localparam logic [1:0] REG_MIX_LENGTH = 2'd2;
    localparam longint unsigned CYCLE_LIMIT = 64'd3000000;

    typedef logic [255:0] node_t;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  valid_bytes;
        logic        last_word;
    } word_item_t;

    typedef struct packed {
        logic [63:0] root_word;
        logic [1:0]  word_index;
        logic        root_last;
        logic        overflow_error;
    } root_item_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [1:0]   cfg_index;
    logic [63:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    merkle_root_sha256_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // predictor state
    logic [5:0]  depth_reg;
    logic        mix_en_reg;
    logic [63:0] mix_len_reg;
    logic [63:0] chunk_words [4];
    int unsigned word_pos;
    longint unsigned chunks_seen;
    node_t       level_node [DEPTH_CAP + 1];
    bit          level_full [DEPTH_CAP + 1];
    node_t       zero_node  [DEPTH_CAP + 1];

    word_item_t  send_q [$];
    root_item_t  root_q [$];
    int          fail_count = 0;
    longint unsigned cycle_count = 0;
    int          send_idle_pct;
    int          recv_idle_pct;

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bswap(logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic void sha_block(ref logic [31:0] h [8], input logic [31:0] blk [16]);
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 64; i++) begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = h[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + mrs256_pkg::RK[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) h[i] = h[i] + v[i];
    endfunction

    // node word k = bytes 8k..8k+7, little-endian
    function automatic node_t pair_hash(node_t l, node_t r);
        logic [31:0] h [8];
        logic [31:0] blk [16];
        logic [511:0] cat;
        node_t o;
        cat = {r, l};
        for (int i = 0; i < 8; i++) h[i] = mrs256_pkg::IV[i];
        for (int i = 0; i < 16; i++) blk[i] = bswap(cat[32*i +: 32]);
        sha_block(h, blk);
        for (int i = 0; i < 16; i++) blk[i] = 32'h0;
        blk[0] = 32'h80000000;
        blk[15] = 32'd512;
        sha_block(h, blk);
        for (int i = 0; i < 8; i++) o[32*i +: 32] = bswap(h[i]);
        return o;
    endfunction

    function automatic void clear_tree();
        for (int k = 0; k < 4; k++) chunk_words[k] = '0;
        word_pos = 0;
        chunks_seen = 0;
        for (int h = 0; h <= DEPTH_CAP; h++) begin
            level_node[h] = '0;
            level_full[h] = 0;
        end
    endfunction

    function automatic void fold_chunk();
        node_t nd;
        int h;
        longint unsigned cap;
        cap = 64'd1 << DEPTH_CAP;
        h = 0;
        if (chunks_seen < cap) begin
            nd = {chunk_words[3], chunk_words[2], chunk_words[1], chunk_words[0]};
            while (h < DEPTH_CAP && level_full[h]) begin
                nd = pair_hash(level_node[h], nd);
                level_full[h] = 0;
                h++;
            end
            level_node[h] = nd;
            level_full[h] = 1;
        end
        if (chunks_seen <= cap) chunks_seen++;
    endfunction

    function automatic void predict_root(word_item_t it);
        logic [63:0] w;
        int vb, fit, cfg, lim, d;
        longint unsigned cnt, cap;
        bit err, have;
        node_t carry, root;
        root_item_t r;
        w = it.data_word;
        vb = it.valid_bytes;
        if (it.last_word) begin
            if (vb == 0 || vb > 8) vb = 8;
            if (vb < 8) w = w & ((64'd1 << (8 * vb)) - 1);
        end
        chunk_words[word_pos] = w;
        if (word_pos == 3 || it.last_word) begin
            fold_chunk();
            for (int k = 0; k < 4; k++) chunk_words[k] = '0;
            word_pos = 0;
        end else begin
            word_pos++;
        end
        if (!it.last_word) return;
        cap = 64'd1 << DEPTH_CAP;
        cnt = chunks_seen < cap ? chunks_seen : cap;
        fit = 0;
        while (fit < DEPTH_CAP && (64'd1 << fit) < cnt) fit++;
        cfg = depth_reg > DEPTH_CAP ? DEPTH_CAP : int'(depth_reg);
        lim = cfg != 0 ? cfg : DEPTH_CAP;
        err = chunks_seen > (64'd1 << lim);
        d = cfg > fit ? cfg : fit;
        have = 0;
        carry = '0;
        for (int h = 0; h < d; h++) begin
            if (level_full[h]) begin
                carry = pair_hash(level_node[h], have ? carry : zero_node[h]);
                have = 1;
            end else if (have) begin
                carry = pair_hash(carry, zero_node[h]);
            end
        end
        root = have ? carry : level_node[d];
        if (mix_en_reg) root = pair_hash(root, {192'h0, mix_len_reg});
        for (int k = 0; k < 4; k++) begin
            r.root_word = root[64*k +: 64];
            r.word_index = k[1:0];
            r.root_last = (k == 3);
            r.overflow_error = err;
            root_q.insert(root_q.size(), r);
        end
        clear_tree();
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $time, what);
        fail_count++;
    endtask

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // driver
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tdata <= '0;
            s_tlast <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid && s_tready) predict_root(send_q.pop_front());
            if (send_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1;
                s_tdata <= {4'h0, send_q[0].valid_bytes, send_q[0].data_word};
                s_tlast <= send_q[0].last_word;
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        root_item_t e;
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (root_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected root word %h", m_tdata));
                end else begin
                    e = root_q.pop_front();
                    if (m_tdata !== e.root_word)
                        report_mismatch($sformatf("root_word %h exp %h", m_tdata, e.root_word));
                    if (m_tuser[1:0] !== e.word_index)
                        report_mismatch($sformatf("word_index %0d exp %0d",
                                                  m_tuser[1:0], e.word_index));
                    if (m_tlast !== e.root_last)
                        report_mismatch($sformatf("root_last %b exp %b", m_tlast, e.root_last));
                    if (m_tuser[2] !== e.overflow_error)
                        report_mismatch($sformatf("overflow_error %b exp %b",
                                                  m_tuser[2], e.overflow_error));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("merkle_root_sha256_top verification failed");
            $finish;
        end
    end

    function automatic void add_stream(int nwords, int vb);
        word_item_t it;
        for (int i = 0; i < nwords; i++) begin
            it.data_word = {$urandom, $urandom};
            it.valid_bytes = (i == nwords - 1) ? vb[3:0] : 4'($urandom_range(15));
            it.last_word = (i == nwords - 1);
            send_q.insert(send_q.size(), it);
        end
    endfunction

    function automatic void add_fixed(logic [63:0] w, logic [3:0] vb, logic last);
        word_item_t it;
        it.data_word = w;
        it.valid_bytes = vb;
        it.last_word = last;
        send_q.insert(send_q.size(), it);
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        if (idx == REG_TREE_DEPTH) depth_reg = val[5:0];
        else if (idx == REG_MIX_ENABLE) mix_en_reg = val[0];
        else mix_len_reg = val;
    endtask

    task automatic drain();
        while (send_q.size() > 0 || s_tvalid || root_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_phase(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            int nw;
            nw = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            add_stream(nw, $urandom_range(15));
            sent += nw;
        end
    endtask

    initial begin
        cfg_wr_en = 0; cfg_index = '0; cfg_wdata = '0;
        aresetn = 0;
        depth_reg = 0; mix_en_reg = 0; mix_len_reg = 0;
        send_idle_pct = 18; recv_idle_pct = 75;
        clear_tree();
        zero_node[0] = '0;
        for (int h = 1; h <= DEPTH_CAP; h++)
            zero_node[h] = pair_hash(zero_node[h-1], zero_node[h-1]);
        repeat (4) @(posedge aclk);
        aresetn <= 1;

        // directed: fitted depth, single and multi-chunk streams, valid-count edge cases
        add_fixed(64'hffffffffffffffff, 4'd0, 1);
        add_fixed(64'h0, 4'd8, 1);
        add_fixed(64'hffffffffffffffff, 4'd1, 1);
        add_fixed(64'ha5a5a5a55a5a5a5a, 4'd15, 1);
        add_fixed(64'h0123456789abcdef, 4'd9, 0);
        add_fixed(64'hfedcba9876543210, 4'd7, 1);
        add_stream(4, 8);
        add_stream(5, 3);
        add_stream(13, 6);
        drain();
        // depth too small -> overflow
        write_reg(REG_TREE_DEPTH, 64'd1);
        add_stream(9, 8);
        add_stream(8, 2);
        drain();
        write_reg(REG_TREE_DEPTH, 64'd63);
        write_reg(REG_MIX_ENABLE, 64'd1);
        write_reg(REG_MIX_LENGTH, 64'hffffffffffffffff);
        add_stream(2, 8);
        drain();
        write_reg(REG_TREE_DEPTH, 64'd32);
        write_reg(REG_MIX_LENGTH, 64'd0);
        add_stream(1, 5);
        drain();

        // random phases across idling patterns and settings
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle_pct = 75; recv_idle_pct = 18; end
            if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
            write_reg(REG_TREE_DEPTH, 64'($urandom_range(5)));
            write_reg(REG_MIX_ENABLE, 64'($urandom_range(1)));
            write_reg(REG_MIX_LENGTH, {$urandom, $urandom});
            random_phase(22);
            drain();
        end
        write_reg(REG_TREE_DEPTH, 64'd0);
        write_reg(REG_MIX_ENABLE, 64'd0);
        add_stream(6, 4);
        drain();

        if (fail_count == 0) begin
            $display("merkle_root_sha256_top verification clean");
        end else begin
            $display("merkle_root_sha256_top verification failed");
        end
        $finish;
    end

endmodule
